### hw/rtl/cpu_reset_sequencer_defines.svh
// Assertion macros shared by the cpu_reset_sequencer checker.
// No dependencies; included by files that carry assertions.
`ifndef CPU_RESET_SEQUENCER_DEFINES_SVH
`define CPU_RESET_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CRS_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("crs assertion failed");

// Next-cycle implication, disabled during reset.
`define CRS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("crs assertion failed");

`endif

### hw/rtl/crs_pkg.sv
// Shared types and constants for the CPU reset sequencer.
// No dependencies; used by every module of the block.
package crs_pkg;

  localparam int PHI2_W             = 24;
  localparam int US_PER_SECOND      = 1000000;
  localparam int RESET_PULSE_CYCLES = 4;
  localparam int DEFAULT_PHI2_HZ    = 1000000;
  localparam int ELAPSED_W          = 32;

  // Input word: request type and sampled pin
  typedef struct packed {
    logic req_type;
    logic ext_reset_n;
  } item_t;

  // Result word
  typedef struct packed {
    logic cpu_resb;
    logic runtime_reset;
    logic release_pending;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_run;
  } crs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } crs_sts_t;

endpackage

### hw/rtl/cpu_reset_sequencer.sv
// Top level of the CPU reset sequencer: controller plus datapath.
// Depends on crs_pkg, crs_ctrl and crs_dp.
//
//   channel   signals                                   word
//   item      item_valid / item_ready / item            req_type, ext_reset_n
//   result    result_valid / result_ready / result      cpu_resb, runtime_reset,
//                                                       release_pending
//   cfg       cfg_valid / cfg_ready / cfg_data          phi2_hz
//
// One word at a time. A word that schedules a release (pulse command or end of
// a request) passes through the bit-serial hold divider, whose NUM_W-bit
// numerator is 25 bits wide at the defaults, before its result shows; other
// words go straight to the result register. The result register then waits for result_ready.
// Reset holds the CPU in reset with no release pending and phi2_hz at zero.
module cpu_reset_sequencer #(
  parameter int RESET_PULSE_CYCLES = crs_pkg::RESET_PULSE_CYCLES,
  parameter int DEFAULT_PHI2_HZ    = crs_pkg::DEFAULT_PHI2_HZ
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  crs_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output crs_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [crs_pkg::PHI2_W-1:0]  cfg_data
);
  import crs_pkg::*;

  crs_cmd_t cmd;
  crs_sts_t sts;

  crs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cfg_ready    (cfg_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  crs_dp #(
    .RESET_PULSE_CYCLES (RESET_PULSE_CYCLES),
    .DEFAULT_PHI2_HZ    (DEFAULT_PHI2_HZ)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule

### hw/rtl/crs_ctrl.sv
// Controller FSM of the CPU reset sequencer: handshakes and divider sequencing.
// Depends on crs_pkg.
module crs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              cfg_ready,
  input  crs_pkg::crs_sts_t sts,
  output crs_pkg::crs_cmd_t cmd
);
  import crs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign item_ready   = (state == ST_IDLE);
  assign cfg_ready    = (state == ST_IDLE);
  assign result_valid = (state == ST_OUT);
  assign cmd.accept   = item_valid && item_ready;
  assign cmd.div_run  = (state == ST_DIV);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_next = sts.need_div ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/crs_dp.sv
// Datapath of the CPU reset sequencer: sequencing state, elapsed counter,
// restoring hold-time divider, config register and result register. Uses crs_pkg.
module crs_dp #(
  parameter int RESET_PULSE_CYCLES = crs_pkg::RESET_PULSE_CYCLES,
  parameter int DEFAULT_PHI2_HZ    = crs_pkg::DEFAULT_PHI2_HZ
) (
  input  logic                        clk,
  input  logic                        rst,
  input  crs_pkg::item_t              item,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [crs_pkg::PHI2_W-1:0]  cfg_data,
  input  crs_pkg::crs_cmd_t           cmd,
  output crs_pkg::crs_sts_t           sts,
  output crs_pkg::result_t            result
);
  import crs_pkg::*;

  localparam int PULSE_US = RESET_PULSE_CYCLES * US_PER_SECOND;
  // numerator = pulse time + f - 1, f below 2**PHI2_W
  localparam int NUM_W    = $clog2(PULSE_US + (2 ** PHI2_W));
  localparam int HOLD_W   = $clog2(PULSE_US + 1);
  localparam int CNT_W    = $clog2(NUM_W);

  // Sequencing state
  logic                 request_seen;
  logic                 pending_flag;
  logic                 reset_asserted;
  logic [ELAPSED_W-1:0] elapsed_us;
  logic [HOLD_W-1:0]    hold_us;
  logic [PHI2_W-1:0]    phi2_hz;

  // Divider
  logic [NUM_W-1:0]  dq;
  logic [PHI2_W-1:0] rem;
  logic [PHI2_W-1:0] dvs;
  logic [CNT_W-1:0]  div_cnt;

  logic                 pulse;
  logic                 requested;
  logic                 sched;
  logic                 strobe;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 seen_next;
  logic                 pending_next;
  logic                 asserted_next;
  logic [PHI2_W-1:0]    f_sel;
  logic [PHI2_W:0]      trial;
  logic                 ge;
  logic [NUM_W-1:0]     dq_next;

  assign pulse     = item.req_type;
  assign requested = !item.ext_reset_n;

  // Item update: tick advances the counter, pulse takes no time
  always_comb begin
    elapsed_inc   = (pending_flag && (elapsed_us != '1)) ? elapsed_us + 1'b1 : elapsed_us;
    sched         = 1'b0;
    strobe        = 1'b0;
    seen_next     = request_seen;
    pending_next  = pending_flag;
    asserted_next = reset_asserted;
    if (pulse) begin
      asserted_next = 1'b1;
      sched         = 1'b1;
      pending_next  = 1'b1;
    end else if (requested) begin
      if (!request_seen) begin
        seen_next    = 1'b1;
        pending_next = 1'b0;
        strobe       = 1'b1;
      end
      asserted_next = 1'b1;
    end else if (request_seen) begin
      // released request: hold is at least one, so no release this tick
      seen_next    = 1'b0;
      sched        = 1'b1;
      pending_next = 1'b1;
    end else if (pending_flag && (elapsed_inc > ELAPSED_W'(hold_us))) begin
      asserted_next = 1'b0;
      pending_next  = 1'b0;
    end
  end

  assign sts.need_div = sched;
  assign sts.div_last = cmd.div_run && (div_cnt == CNT_W'(NUM_W - 1));

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      request_seen   <= 1'b0;
      pending_flag   <= 1'b0;
      reset_asserted <= 1'b1;
      elapsed_us     <= '0;
      phi2_hz        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        phi2_hz <= cfg_data;
      end
      if (cmd.accept) begin
        request_seen   <= seen_next;
        pending_flag   <= pending_next;
        reset_asserted <= asserted_next;
        elapsed_us     <= sched ? '0 : (pulse ? elapsed_us : elapsed_inc);
      end
    end
  end

  // Result word, held until taken
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      result.cpu_resb        <= !asserted_next;
      result.runtime_reset   <= strobe;
      result.release_pending <= pending_next;
    end
  end

  // Restoring divider, one quotient bit a cycle
  assign f_sel   = (phi2_hz == '0) ? PHI2_W'(DEFAULT_PHI2_HZ) : phi2_hz;
  assign trial   = {rem, dq[NUM_W-1]};
  assign ge      = (trial >= {1'b0, dvs});
  assign dq_next = {dq[NUM_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_us <= '0;
      div_cnt <= '0;
    end else if (cmd.accept && sched) begin
      div_cnt <= '0;
    end else if (cmd.div_run) begin
      div_cnt <= div_cnt + 1'b1;
      if (sts.div_last) begin
        hold_us <= dq_next[HOLD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sched) begin
      dq  <= NUM_W'(PULSE_US) + NUM_W'(f_sel) - NUM_W'(1);
      rem <= '0;
      dvs <= f_sel;
    end else if (cmd.div_run) begin
      dq  <= dq_next;
      rem <= ge ? PHI2_W'(trial - {1'b0, dvs}) : PHI2_W'(trial);
    end
  end

endmodule

### hw/rtl/crs_checker.sv
// Port-level checks for cpu_reset_sequencer, bound to the top level.
// Depends on crs_pkg and cpu_reset_sequencer_defines.svh.
`include "cpu_reset_sequencer_defines.svh"

module crs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input crs_pkg::item_t              item,
  input logic                        result_valid,
  input logic                        result_ready,
  input crs_pkg::result_t            result,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [crs_pkg::PHI2_W-1:0]  cfg_data
);
  import crs_pkg::*;

  // A new request always comes with the CPU held in reset
  `CRS_ASSERT_NOW(a_strobe_in_reset, clk, rst, result_valid && result.runtime_reset, !result.cpu_resb)

  // A waiting release implies the CPU is still held
  `CRS_ASSERT_NOW(a_pending_held, clk, rst, result_valid && result.release_pending, !result.cpu_resb)

  // One word in flight: an accepted word blocks the input next cycle
  `CRS_ASSERT_NEXT(a_one_in_flight, clk, rst, item_valid && item_ready, !item_ready)

  // A stalled result word holds
  `CRS_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind cpu_reset_sequencer crs_checker u_crs_checker (.*);
